/* rtl/bdq_pkg.sv */
package bdq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;
  localparam int FUNC_W    = 3;
  localparam int STATUS_W  = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_DUMP       = 3'd4
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESP,
    S_DUMP_RD,
    S_DUMP_WAIT
  } state_t;

endpackage

/* rtl/bdq_cmd_if.sv */
interface bdq_cmd_if;
  import bdq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

/* rtl/bdq_rsp_if.sv */
interface bdq_rsp_if;
  import bdq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] word;
  logic [STATUS_W-1:0]      status;
  logic                     last;

  modport source (output valid, output word, output status, output last, input ready);
  modport sink   (input valid, input word, input status, input last, output ready);
endinterface

/* rtl/bounded_deque_with_dump_core.sv */
// Push and pop: accepted in S_IDLE; S_RESP loads the result when the output is free.
// Dump of n words: per word, S_DUMP_RD reads the store, S_DUMP_WAIT loads the output.
// The next item is accepted while the previous result waits in the output register.
// Synchronous active-high reset empties the queue (front and count to zero).
// The word store has no reset; only entries that hold queued words are read.
module bounded_deque_with_dump_core #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  bdq_cmd_if.sink   cmd,
  bdq_rsp_if.source rsp
);
  import bdq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_A = (AW+1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_A) s = s - DEPTH_A;
    return s[AW-1:0];
  endfunction

  state_t        state, state_next;
  logic [AW-1:0] front_ptr, front_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  status_t       pend, pend_next;

  logic                     out_valid;
  logic signed [WORD_W-1:0] out_word, out_word_next;
  status_t                  out_status, out_status_next;
  logic                     out_last, out_last_next;
  logic                     load_out;
  logic                     out_free;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;

  logic cmd_fire;
  logic full, empty;

  assign cmd.ready  = (state == S_IDLE);
  assign cmd_fire   = cmd.valid && cmd.ready;
  assign out_free   = !out_valid || rsp.ready;
  assign full       = (count >= DEPTH_C);
  assign empty      = (count == '0);
  assign mem_raddr  = wrap_add(front_ptr, idx[AW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front_ptr <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      front_ptr <= front_next;
      count     <= count_next;
      if (load_out) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    idx  <= idx_next;
    pend <= pend_next;
    if (load_out) begin
      out_word   <= out_word_next;
      out_status <= out_status_next;
      out_last   <= out_last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= cmd.value;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[mem_raddr];
  end

  always_comb begin
    state_next      = state;
    front_next      = front_ptr;
    count_next      = count;
    idx_next        = idx;
    pend_next       = pend;
    mem_we          = 1'b0;
    mem_waddr       = wrap_add(front_ptr, count[AW-1:0]);
    load_out        = 1'b0;
    out_word_next   = '0;
    out_status_next = ST_OK;
    out_last_next   = 1'b1;
    case (state)
      S_IDLE: begin
        if (cmd_fire) begin
          case (func_t'(cmd.func))
            FN_PUSH_FRONT: begin
              state_next = S_RESP;
              if (full) begin
                pend_next = ST_FULL;
              end else begin
                pend_next  = ST_OK;
                front_next = (front_ptr == '0) ? LAST_A : front_ptr - AW'(1);
                mem_waddr  = front_next;
                mem_we     = 1'b1;
                count_next = count + CW'(1);
              end
            end
            FN_PUSH_BACK: begin
              state_next = S_RESP;
              if (full) begin
                pend_next = ST_FULL;
              end else begin
                pend_next  = ST_OK;
                mem_we     = 1'b1;
                count_next = count + CW'(1);
              end
            end
            FN_POP_FRONT: begin
              state_next = S_RESP;
              if (empty) begin
                pend_next = ST_EMPTY;
              end else begin
                pend_next  = ST_OK;
                front_next = wrap_add(front_ptr, AW'(1));
                count_next = count - CW'(1);
              end
            end
            FN_POP_BACK: begin
              state_next = S_RESP;
              if (empty) begin
                pend_next = ST_EMPTY;
              end else begin
                pend_next  = ST_OK;
                count_next = count - CW'(1);
              end
            end
            FN_DUMP: begin
              idx_next = '0;
              if (empty) begin
                pend_next  = ST_EMPTY;
                state_next = S_RESP;
              end else begin
                state_next = S_DUMP_RD;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_RESP: begin
        if (out_free) begin
          load_out        = 1'b1;
          out_status_next = pend;
          state_next      = S_IDLE;
        end
      end
      S_DUMP_RD: begin
        state_next = S_DUMP_WAIT;
      end
      S_DUMP_WAIT: begin
        if (out_free) begin
          load_out      = 1'b1;
          out_word_next = rdata;
          out_last_next = ((idx + CW'(1)) == count);
          idx_next      = idx + CW'(1);
          state_next    = out_last_next ? S_IDLE : S_DUMP_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign rsp.valid  = out_valid;
  assign rsp.word   = out_word;
  assign rsp.status = out_status;
  assign rsp.last   = out_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("count above depth");

  a_dump_holds_queue: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP_RD || state == S_DUMP_WAIT) |=> $stable(count) && $stable(front_ptr))
    else $error("queue changed during dump");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    cmd_fire && !full && (cmd.func == FN_PUSH_FRONT || cmd.func == FN_PUSH_BACK)
    |=> count == $past(count) + CW'(1))
    else $error("push did not grow queue");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd_fire && empty && (cmd.func == FN_POP_FRONT || cmd.func == FN_POP_BACK)
    |=> pend == ST_EMPTY && count == '0)
    else $error("pop on empty queue mishandled");

  a_dump_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP_RD || state == S_DUMP_WAIT) |-> idx < count)
    else $error("dump index past queue end");

endmodule
